### design/qri_pkg.sv
// shared widths, result codes and cell link types for the quadratic root solver
package qri_pkg;

  localparam int COEFF_W   = 16;
  localparam int FRAC_BITS = 16;
  localparam int DISC_W    = 36;
  localparam int ROOT_W    = 34;
  localparam int VALUE_W   = 48;

  localparam int ABC_W       = COEFF_W + 1;
  localparam int SQRT_STEPS  = DISC_W / 2 + FRAC_BITS;
  localparam int DIV_NW      = 35;
  localparam int DIV_DW      = COEFF_W + 1;
  localparam int DIV_STEPS   = DIV_NW;
  localparam int EVAL_STAGES = 6;

  localparam logic [2:0] CASE_INFINITE = 3'd0;
  localparam logic [2:0] CASE_NONE     = 3'd1;
  localparam logic [2:0] CASE_LINEAR   = 3'd2;
  localparam logic [2:0] CASE_DOUBLE   = 3'd3;
  localparam logic [2:0] CASE_TWO      = 3'd4;
  localparam logic [2:0] CASE_UNSUP    = 3'd5;

  typedef struct packed {
    logic [DISC_W-1:0]     d;
    logic [DISC_W-1:0]     rem;
    logic [SQRT_STEPS-1:0] root;
  } sq_t;

  typedef struct packed {
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] rem;
    logic [DIV_NW-1:0] quo;
    logic [DIV_DW-1:0] den;
  } dv_t;

endpackage

### design/qri_sqrt_cell.sv
// one restoring square root step, one result bit per cell
module qri_sqrt_cell (
  input  logic          clk,
  input  logic          en,
  input  qri_pkg::sq_t  sq_in,
  output qri_pkg::sq_t  sq_out
);

  logic [qri_pkg::DISC_W+1:0] rem_s;
  logic [qri_pkg::DISC_W+1:0] trial;
  qri_pkg::sq_t               sq_next;

  always_comb begin
    rem_s = {sq_in.rem, sq_in.d[qri_pkg::DISC_W-1 -: 2]};
    trial = (qri_pkg::DISC_W+2)'({sq_in.root, 2'b01});
    sq_next.d = sq_in.d << 2;
    if (rem_s >= trial) begin
      sq_next.rem  = qri_pkg::DISC_W'(rem_s - trial);
      sq_next.root = {sq_in.root[qri_pkg::SQRT_STEPS-2:0], 1'b1};
    end else begin
      sq_next.rem  = rem_s[qri_pkg::DISC_W-1:0];
      sq_next.root = {sq_in.root[qri_pkg::SQRT_STEPS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_out <= sq_next;
    end
  end

endmodule

### design/qri_div_cell.sv
// one restoring division step, one quotient bit per cell
module qri_div_cell (
  input  logic          clk,
  input  logic          en,
  input  qri_pkg::dv_t  dv_in,
  output qri_pkg::dv_t  dv_out
);

  logic [qri_pkg::DIV_DW:0] rem_s;
  qri_pkg::dv_t             dv_next;

  always_comb begin
    rem_s       = {dv_in.rem, dv_in.num[qri_pkg::DIV_NW-1]};
    dv_next.num = dv_in.num << 1;
    dv_next.den = dv_in.den;
    if (rem_s >= {1'b0, dv_in.den}) begin
      dv_next.rem = qri_pkg::DIV_DW'(rem_s - {1'b0, dv_in.den});
      dv_next.quo = {dv_in.quo[qri_pkg::DIV_NW-2:0], 1'b1};
    end else begin
      dv_next.rem = rem_s[qri_pkg::DIV_DW-1:0];
      dv_next.quo = {dv_in.quo[qri_pkg::DIV_NW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_out <= dv_next;
    end
  end

endmodule

### design/qri_eval.sv
// pipelined evaluation of the first polynomial at a fixed point root
module qri_eval (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [qri_pkg::COEFF_W-1:0]  s1,
  input  logic signed [qri_pkg::COEFF_W-1:0]  l1,
  input  logic signed [qri_pkg::COEFF_W-1:0]  c1,
  input  logic signed [qri_pkg::ROOT_W-1:0]   x,
  output logic signed [qri_pkg::VALUE_W-1:0]  value
);

  localparam int CW   = qri_pkg::COEFF_W;
  localparam int XW   = qri_pkg::ROOT_W;
  localparam int AXW  = CW + XW;
  localparam int MW   = AXW + 1;
  localparam int MLW  = 26;
  localparam int MHW  = MW - MLW;
  localparam int XLW  = 17;
  localparam int XHW  = XW - XLW;
  localparam int PW   = MLW + XLW + 1;
  localparam int VW   = 88;
  localparam int T2W  = MHW + XLW + XHW + 4;
  localparam int SW   = VW - qri_pkg::FRAC_BITS;
  localparam int HIW  = SW - qri_pkg::VALUE_W + 1;

  logic signed [AXW-1:0] ax;
  logic signed [XW-1:0]  x1, x2;
  logic signed [CW-1:0]  l1_1;
  logic signed [CW-1:0]  c1_1, c1_2, c1_3;
  logic signed [MW-1:0]  m;
  logic signed [PW-1:0]  p00, p01, p10, p11;
  logic signed [VW-1:0]  t1;
  logic signed [T2W-1:0] t2;
  logic signed [VW-1:0]  v;
  logic [SW-1:0]         vs;
  logic [HIW-1:0]        vs_hi;

  always_ff @(posedge clk) begin
    if (en) begin
      ax   <= s1 * x;
      x1   <= x;
      l1_1 <= l1;
      c1_1 <= c1;

      m    <= MW'(ax) + (MW'(l1_1) <<< qri_pkg::FRAC_BITS);
      x2   <= x1;
      c1_2 <= c1_1;

      p00  <= $signed({1'b0, m[MLW-1:0]}) * $signed({1'b0, x2[XLW-1:0]});
      p01  <= $signed({1'b0, m[MLW-1:0]}) * $signed(x2[XW-1:XLW]);
      p10  <= $signed(m[MW-1:MLW]) * $signed({1'b0, x2[XLW-1:0]});
      p11  <= $signed(m[MW-1:MLW]) * $signed(x2[XW-1:XLW]);
      c1_3 <= c1_2;

      t1   <= VW'(p00) + (VW'(p01) <<< XLW) + (VW'(c1_3) <<< (2 * qri_pkg::FRAC_BITS));
      t2   <= T2W'(p10) + (T2W'(p11) <<< XLW);

      v    <= t1 + (VW'(t2) <<< MLW);

      if ((&vs_hi) || !(|vs_hi)) begin
        value <= vs[qri_pkg::VALUE_W-1:0];
      end else if (v[VW-1]) begin
        value <= {1'b1, {(qri_pkg::VALUE_W-1){1'b0}}};
      end else begin
        value <= {1'b0, {(qri_pkg::VALUE_W-1){1'b1}}};
      end
    end
  end

  assign vs    = v[VW-1:qri_pkg::FRAC_BITS];
  assign vs_hi = vs[SW-1:qri_pkg::VALUE_W-1];

endmodule

### design/quadratic_root_intersection_top.sv
// top level of the quadratic root and intersection solver
// Accepts one request per clock while the output side is ready and returns one result
// per request, in order. A request passes the coefficient and discriminant stages, the
// 34-cell square root chain, the two 35-cell divider chains that follow it, and the sign
// correction and six-stage evaluation stages. The whole pipeline holds while a result
// waits at the output register and moves on as soon as it is taken, so the sustained
// rate is one request per cycle whenever the output side is ready.
module quadratic_root_intersection_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // first_degree, first_square, first_linear, first_constant,
  // second_degree, second_square, second_linear, second_constant, zero fill
  input  logic [103:0] s_axis_tdata,
  // operation
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // discriminant, root_high, root_low, value_high, value_low
  output logic [199:0] m_axis_tdata,
  // case_code
  output logic [2:0]   m_axis_tuser
);

  localparam int CW    = qri_pkg::COEFF_W;
  localparam int AW    = qri_pkg::ABC_W;
  localparam int DW    = qri_pkg::DISC_W;
  localparam int RW    = qri_pkg::ROOT_W;
  localparam int VW    = qri_pkg::VALUE_W;
  localparam int NSW   = qri_pkg::DIV_NW + 2;
  localparam int DSW   = qri_pkg::DIV_DW + 1;
  localparam int DEPTH = 3 + qri_pkg::SQRT_STEPS + 1 + qri_pkg::DIV_STEPS + 1
                         + qri_pkg::EVAL_STAGES + 1;
  localparam logic [qri_pkg::DIV_NW-1:0] POS_LIM =
    {{(qri_pkg::DIV_NW-RW+1){1'b0}}, {(RW-1){1'b1}}};
  localparam logic [qri_pkg::DIV_NW-1:0] NEG_LIM = POS_LIM + 1'b1;

  typedef struct packed {
    logic [2:0]           code;
    logic                 unsup;
    logic signed [DW-1:0] disc;
    logic signed [AW-1:0] a;
    logic signed [AW-1:0] b;
    logic signed [AW-1:0] c;
    logic signed [CW-1:0] s1;
    logic signed [CW-1:0] l1;
    logic signed [CW-1:0] c1;
  } ctx_t;

  typedef struct packed {
    logic [2:0]           code;
    logic signed [DW-1:0] disc;
    logic signed [CW-1:0] s1;
    logic signed [CW-1:0] l1;
    logic signed [CW-1:0] c1;
    logic                 neg_h;
    logic                 neg_l;
  } tail_t;

  typedef struct packed {
    logic [2:0]           code;
    logic signed [DW-1:0] disc;
    logic signed [RW-1:0] rh;
    logic signed [RW-1:0] rl;
  } res_t;

  logic             adv;
  logic [DEPTH-1:0] vld;

  logic [1:0]           g1, g2;
  logic                 op;
  logic signed [CW-1:0] s1m, l1m, s2m, l2m, c1i, c2i;
  ctx_t                 ctx_in, ctx0, ctx1, ctx2;
  ctx_t                 ctx2_next;
  logic signed [2*AW-1:0] bb, ac;
  logic signed [DW-1:0] disc_c;
  logic [2:0]           code_c;

  ctx_t                 ctx_sq [0:qri_pkg::SQRT_STEPS-1];
  qri_pkg::sq_t         sq_link [0:qri_pkg::SQRT_STEPS];

  ctx_t                 cn;
  logic signed [NSW-1:0] num_h, num_l, bterm;
  logic signed [DSW-1:0] den;
  logic [NSW-1:0]       mag_h, mag_l;
  logic [DSW-1:0]       mag_d;
  qri_pkg::dv_t         dv_h_link [0:qri_pkg::DIV_STEPS];
  qri_pkg::dv_t         dv_l_link [0:qri_pkg::DIV_STEPS];
  tail_t                tail_n;
  tail_t                tail_dv [0:qri_pkg::DIV_STEPS-1];

  logic signed [RW-1:0] rh_c, rl_c;
  logic                 has_root;
  res_t                 res_r;
  logic signed [CW-1:0] es1, el1, ec1;
  res_t                 res_ev [0:qri_pkg::EVAL_STAGES-1];
  logic signed [VW-1:0] val_h, val_l;
  logic                 has_val;

  logic [2:0]           out_code;
  logic signed [DW-1:0] out_disc;
  logic signed [RW-1:0] out_rh, out_rl;
  logic signed [VW-1:0] out_vh, out_vl;

  function automatic logic signed [RW-1:0] root_sat(input logic [qri_pkg::DIV_NW-1:0] q,
                                                     input logic neg);
    logic signed [RW-1:0] r;
    if (!neg) begin
      r = (q > POS_LIM) ? RW'(POS_LIM) : RW'(q);
    end else begin
      r = (q > NEG_LIM) ? RW'(NEG_LIM) : -RW'(q);
    end
    return r;
  endfunction

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-2:0], s_axis_tvalid};
    end
  end

  // coefficient selection
  always_comb begin
    op  = s_axis_tuser[0];
    g1  = s_axis_tdata[1:0];
    g2  = s_axis_tdata[51:50];
    s1m = (g1 >= 2'd2) ? $signed(s_axis_tdata[17:2])  : '0;
    l1m = (g1 >= 2'd1) ? $signed(s_axis_tdata[33:18]) : '0;
    c1i = $signed(s_axis_tdata[49:34]);
    s2m = (g2 >= 2'd2) ? $signed(s_axis_tdata[67:52]) : '0;
    l2m = (g2 >= 2'd1) ? $signed(s_axis_tdata[83:68]) : '0;
    c2i = $signed(s_axis_tdata[99:84]);
    ctx_in.code  = qri_pkg::CASE_UNSUP;
    ctx_in.unsup = (g1 == 2'd3) || (op && (g2 == 2'd3));
    ctx_in.disc  = '0;
    ctx_in.a     = op ? (AW'(s1m) - AW'(s2m)) : AW'(s1m);
    ctx_in.b     = op ? (AW'(l1m) - AW'(l2m)) : AW'(l1m);
    ctx_in.c     = op ? (AW'(c1i) - AW'(c2i)) : AW'(c1i);
    ctx_in.s1    = s1m;
    ctx_in.l1    = l1m;
    ctx_in.c1    = c1i;
  end

  // discriminant and case decision
  always_comb begin
    disc_c = DW'(bb) - (DW'(ac) <<< 2);
    if (ctx1.unsup) begin
      code_c = qri_pkg::CASE_UNSUP;
    end else if (ctx1.a == '0) begin
      if (ctx1.b != '0) begin
        code_c = qri_pkg::CASE_LINEAR;
      end else if (ctx1.c == '0) begin
        code_c = qri_pkg::CASE_INFINITE;
      end else begin
        code_c = qri_pkg::CASE_NONE;
      end
    end else if (disc_c < 0) begin
      code_c = qri_pkg::CASE_NONE;
    end else if (disc_c == '0) begin
      code_c = qri_pkg::CASE_DOUBLE;
    end else begin
      code_c = qri_pkg::CASE_TWO;
    end
    ctx2_next      = ctx1;
    ctx2_next.code = code_c;
    ctx2_next.disc = ctx1.unsup ? '0 : disc_c;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx0 <= ctx_in;
      ctx1 <= ctx0;
      bb   <= ctx0.b * ctx0.b;
      ac   <= ctx0.a * ctx0.c;
      ctx2 <= ctx2_next;
      ctx_sq[0] <= ctx2;
      for (int i = 1; i < qri_pkg::SQRT_STEPS; i++) begin
        ctx_sq[i] <= ctx_sq[i-1];
      end
    end
  end

  assign sq_link[0].d    = ctx2.disc;
  assign sq_link[0].rem  = '0;
  assign sq_link[0].root = '0;

  for (genvar i = 0; i < qri_pkg::SQRT_STEPS; i++) begin : g_sqrt
    qri_sqrt_cell u_cell (
      .clk    (clk),
      .en     (adv),
      .sq_in  (sq_link[i]),
      .sq_out (sq_link[i+1])
    );
  end

  // numerators and denominator
  always_comb begin
    cn    = ctx_sq[qri_pkg::SQRT_STEPS-1];
    bterm = -(NSW'(cn.b) <<< qri_pkg::FRAC_BITS);
    if (cn.code == qri_pkg::CASE_LINEAR) begin
      num_h = -(NSW'(cn.c) <<< qri_pkg::FRAC_BITS);
      num_l = num_h;
      den   = DSW'(cn.b);
    end else begin
      num_h = bterm + $signed({2'b00, sq_link[qri_pkg::SQRT_STEPS].root});
      num_l = bterm - $signed({2'b00, sq_link[qri_pkg::SQRT_STEPS].root});
      den   = DSW'(cn.a) <<< 1;
    end
    mag_h = num_h[NSW-1] ? NSW'(-num_h) : NSW'(num_h);
    mag_l = num_l[NSW-1] ? NSW'(-num_l) : NSW'(num_l);
    mag_d = den[DSW-1] ? DSW'(-den) : DSW'(den);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_h_link[0].num <= mag_h[qri_pkg::DIV_NW-1:0];
      dv_h_link[0].rem <= '0;
      dv_h_link[0].quo <= '0;
      dv_h_link[0].den <= mag_d[qri_pkg::DIV_DW-1:0];
      dv_l_link[0].num <= mag_l[qri_pkg::DIV_NW-1:0];
      dv_l_link[0].rem <= '0;
      dv_l_link[0].quo <= '0;
      dv_l_link[0].den <= mag_d[qri_pkg::DIV_DW-1:0];
      tail_n.code  <= cn.code;
      tail_n.disc  <= cn.disc;
      tail_n.s1    <= cn.s1;
      tail_n.l1    <= cn.l1;
      tail_n.c1    <= cn.c1;
      tail_n.neg_h <= num_h[NSW-1] ^ den[DSW-1];
      tail_n.neg_l <= num_l[NSW-1] ^ den[DSW-1];
      tail_dv[0] <= tail_n;
      for (int j = 1; j < qri_pkg::DIV_STEPS; j++) begin
        tail_dv[j] <= tail_dv[j-1];
      end
    end
  end

  for (genvar j = 0; j < qri_pkg::DIV_STEPS; j++) begin : g_div
    qri_div_cell u_cell_h (
      .clk    (clk),
      .en     (adv),
      .dv_in  (dv_h_link[j]),
      .dv_out (dv_h_link[j+1])
    );
    qri_div_cell u_cell_l (
      .clk    (clk),
      .en     (adv),
      .dv_in  (dv_l_link[j]),
      .dv_out (dv_l_link[j+1])
    );
  end

  // sign, saturation and root masking
  always_comb begin
    has_root = (tail_dv[qri_pkg::DIV_STEPS-1].code == qri_pkg::CASE_LINEAR)
            || (tail_dv[qri_pkg::DIV_STEPS-1].code == qri_pkg::CASE_DOUBLE)
            || (tail_dv[qri_pkg::DIV_STEPS-1].code == qri_pkg::CASE_TWO);
    rh_c = has_root ? root_sat(dv_h_link[qri_pkg::DIV_STEPS].quo,
                               tail_dv[qri_pkg::DIV_STEPS-1].neg_h) : '0;
    rl_c = has_root ? root_sat(dv_l_link[qri_pkg::DIV_STEPS].quo,
                               tail_dv[qri_pkg::DIV_STEPS-1].neg_l) : '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r.code <= tail_dv[qri_pkg::DIV_STEPS-1].code;
      res_r.disc <= tail_dv[qri_pkg::DIV_STEPS-1].disc;
      res_r.rh   <= rh_c;
      res_r.rl   <= rl_c;
      es1        <= tail_dv[qri_pkg::DIV_STEPS-1].s1;
      el1        <= tail_dv[qri_pkg::DIV_STEPS-1].l1;
      ec1        <= tail_dv[qri_pkg::DIV_STEPS-1].c1;
      res_ev[0]  <= res_r;
      for (int k = 1; k < qri_pkg::EVAL_STAGES; k++) begin
        res_ev[k] <= res_ev[k-1];
      end
    end
  end

  qri_eval u_eval_h (
    .clk   (clk),
    .en    (adv),
    .s1    (es1),
    .l1    (el1),
    .c1    (ec1),
    .x     (res_r.rh),
    .value (val_h)
  );

  qri_eval u_eval_l (
    .clk   (clk),
    .en    (adv),
    .s1    (es1),
    .l1    (el1),
    .c1    (ec1),
    .x     (res_r.rl),
    .value (val_l)
  );

  assign has_val = (res_ev[qri_pkg::EVAL_STAGES-1].code == qri_pkg::CASE_LINEAR)
                || (res_ev[qri_pkg::EVAL_STAGES-1].code == qri_pkg::CASE_DOUBLE)
                || (res_ev[qri_pkg::EVAL_STAGES-1].code == qri_pkg::CASE_TWO);

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      out_code <= res_ev[qri_pkg::EVAL_STAGES-1].code;
      out_disc <= res_ev[qri_pkg::EVAL_STAGES-1].disc;
      out_rh   <= res_ev[qri_pkg::EVAL_STAGES-1].rh;
      out_rl   <= res_ev[qri_pkg::EVAL_STAGES-1].rl;
      out_vh   <= has_val ? val_h : '0;
      out_vl   <= has_val ? val_l : '0;
    end
  end

  assign m_axis_tuser = out_code;
  assign m_axis_tdata = {out_vl, out_vh, out_rl, out_rh, out_disc};

  a_no_root_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == qri_pkg::CASE_NONE
      || m_axis_tuser == qri_pkg::CASE_INFINITE || m_axis_tuser == qri_pkg::CASE_UNSUP)
    |-> (m_axis_tdata[199:36] == '0))
    else $error("roots or values set without a real root");

  a_unsup_disc: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == qri_pkg::CASE_UNSUP) |-> (m_axis_tdata[35:0] == '0))
    else $error("discriminant set for unsupported degree");

  a_single_root: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == qri_pkg::CASE_LINEAR
      || m_axis_tuser == qri_pkg::CASE_DOUBLE)
    |-> (m_axis_tdata[69:36] == m_axis_tdata[103:70])
        && (m_axis_tdata[151:104] == m_axis_tdata[199:152]))
    else $error("single root lanes disagree");

  a_two_disc: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == qri_pkg::CASE_TWO)
    |-> ($signed(m_axis_tdata[35:0]) > 0))
    else $error("two roots without positive discriminant");

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

### sim/quadratic_root_intersection_top_tb.sv
// testbench for the quadratic root and intersection solver, checked against a predictor
module quadratic_root_intersection_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    bit               op;
    bit [1:0]         g1;
    bit signed [15:0] s1, l1, c1;
    bit [1:0]         g2;
    bit signed [15:0] s2, l2, c2;
  } request_t;

  typedef struct {
    bit [2:0]  code;
    bit [35:0] disc;
    bit [33:0] rh, rl;
    bit [47:0] vh, vl;
  } solution_t;

  typedef struct {
    request_t  req;
    bit        typed;
    solution_t sol;
  } row_t;

  logic clk = 0, rst = 1;
  logic s_axis_tvalid = 0, m_axis_tready = 0;
  logic [103:0] s_axis_tdata = '0;
  logic [0:0] s_axis_tuser = '0;
  logic s_axis_tready, m_axis_tvalid;
  logic [199:0] m_axis_tdata;
  logic [2:0] m_axis_tuser;

  solution_t solutions_due[$];
  int errors = 0;
  int cycles = 0;
  int hold_off = 0;
  bit hold_start = 0;
  bit hold_taken = 0;
  bit sending_done = 0;
  localparam int CYCLE_LIMIT = 400000;

  quadratic_root_intersection_top dut (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  function automatic longint sat_to(longint v, int w);
    longint mx, mn;
    mx = (longint'(1) <<< (w - 1)) - 1;
    mn = -mx - 1;
    return v > mx ? mx : (v < mn ? mn : v);
  endfunction

  function automatic longint fixed_sqrt(longint d);
    bit [127:0] x;
    bit [127:0] r;
    x = 128'(d) << 32;
    r = 0;
    for (int k = 63; k >= 0; k--)
      if ((r | (128'(1) << k)) * (r | (128'(1) << k)) <= x) r |= 128'(1) << k;
    return longint'(r);
  endfunction

  function automatic longint root_quotient(longint num, longint den);
    longint q;
    if (den == 0) return 0;
    q = num / den;
    return sat_to(q, 34);
  endfunction

  function automatic longint poly_value(longint a, longint b, longint c, longint x);
    logic signed [127:0] v, f;
    v = 128'(a) * x * x + (128'(b) * x <<< 16) + (128'(c) <<< 32);
    f = v >>> 16;
    if (f > 128'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
    if (f < -128'sh8000_0000_0000) return -64'sh8000_0000_0000;
    return longint'(f);
  endfunction

  function automatic solution_t solve_request(request_t r);
    solution_t o;
    longint s1, l1, c1, s2, l2, c2, a, b, c, d, rh, rl, s;
    o = '{default: 0};
    s1 = r.g1 < 2 ? 0 : r.s1; l1 = r.g1 < 1 ? 0 : r.l1; c1 = r.c1;
    s2 = r.g2 < 2 ? 0 : r.s2; l2 = r.g2 < 1 ? 0 : r.l2; c2 = r.c2;
    if (r.g1 == 3 || (r.op && r.g2 == 3)) begin
      o.code = qri_pkg::CASE_UNSUP;
      return o;
    end
    a = r.op ? s1 - s2 : s1; b = r.op ? l1 - l2 : l1; c = r.op ? c1 - c2 : c1;
    d = b * b - 4 * a * c;
    rh = 0; rl = 0;
    if (a == 0) begin
      if (b == 0) o.code = c == 0 ? qri_pkg::CASE_INFINITE : qri_pkg::CASE_NONE;
      else begin
        o.code = qri_pkg::CASE_LINEAR; rh = root_quotient(-c * 65536, b); rl = rh;
      end
    end else if (d < 0) o.code = qri_pkg::CASE_NONE;
    else if (d == 0) begin
      o.code = qri_pkg::CASE_DOUBLE; rh = root_quotient(-b * 65536, 2 * a); rl = rh;
    end else begin
      s = fixed_sqrt(d);
      o.code = qri_pkg::CASE_TWO;
      rh = root_quotient(-b * 65536 + s, 2 * a);
      rl = root_quotient(-b * 65536 - s, 2 * a);
    end
    if (o.code >= qri_pkg::CASE_LINEAR) begin
      o.vh = 48'(poly_value(s1, l1, c1, rh));
      o.vl = 48'(poly_value(s1, l1, c1, rl));
    end
    o.rh = 34'(rh); o.rl = 34'(rl);
    o.disc = 36'(sat_to(d, 36));
    return o;
  endfunction

  function automatic request_t random_request();
    request_t r;
    int mode;
    mode = $urandom_range(0, 9);
    r.op = 1'($urandom);
    r.g1 = 2'($urandom_range(0, 9) == 0 ? 3 : $urandom_range(0, 2));
    r.g2 = 2'($urandom_range(0, 9) == 0 ? 3 : $urandom_range(0, 2));
    {r.s1, r.l1, r.c1, r.s2, r.l2, r.c2} = {$urandom, $urandom, $urandom};
    if (mode < 4) begin
      r.s1 = 16'($urandom_range(0, 40) - 20); r.l1 = 16'($urandom_range(0, 400) - 200);
      r.c1 = 16'($urandom_range(0, 400) - 200); r.s2 = 16'($urandom_range(0, 40) - 20);
      r.l2 = 16'($urandom_range(0, 400) - 200); r.c2 = 16'($urandom_range(0, 400) - 200);
    end else if (mode == 4) begin
      r.s2 = r.s1;
    end
    return r;
  endfunction

  row_t table_rows[$];

  function automatic request_t mk(bit op, bit [1:0] g1, int s1, int l1, int c1,
                                  bit [1:0] g2, int s2, int l2, int c2);
    request_t r;
    r = '{op, g1, 16'(s1), 16'(l1), 16'(c1), g2, 16'(s2), 16'(l2), 16'(c2)};
    return r;
  endfunction

  task automatic add_row(request_t r, bit typed, solution_t s);
    table_rows.push_back('{r, typed, s});
  endtask

  task automatic send(request_t r);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? ($urandom_range(0, 9) == 0 ? $urandom_range(5, 30)
                                                              : $urandom_range(1, 3)) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata <= {4'b0000, r.c2, r.l2, r.s2, r.g2, r.c1, r.l1, r.s1, r.g1};
    s_axis_tuser <= r.op;
    s_axis_tvalid <= 1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    solutions_due.push_back(solve_request(r));
    @(negedge clk);
  endtask

  initial begin
    solution_t z;
    solution_t typed_sol;
    z = '{default: 0};
    add_row(mk(0, 3, 5, 5, 5, 0, 0, 0, 0), 1, '{qri_pkg::CASE_UNSUP, 0, 0, 0, 0, 0});
    add_row(mk(1, 1, 5, 5, 5, 3, 0, 0, 0), 1, '{qri_pkg::CASE_UNSUP, 0, 0, 0, 0, 0});
    add_row(mk(0, 0, 7, 7, 0, 0, 0, 0, 0), 1, '{qri_pkg::CASE_INFINITE, 0, 0, 0, 0, 0});
    add_row(mk(0, 0, 7, 7, 9, 0, 0, 0, 0), 1, '{qri_pkg::CASE_NONE, 0, 0, 0, 0, 0});
    add_row(mk(0, 2, 1, 0, 1, 0, 0, 0, 0), 1, '{qri_pkg::CASE_NONE, -36'sd4, 0, 0, 0, 0});
    typed_sol = '{qri_pkg::CASE_DOUBLE, 0, 0, 0, 0, 0};
    add_row(mk(0, 2, 1, 0, 0, 0, 0, 0, 0), 1, typed_sol);
    add_row(mk(0, 1, 9, 2, -4, 0, 0, 0, 0), 0, z);
    add_row(mk(0, 2, 1, 0, -4, 0, 0, 0, 0), 0, z);
    add_row(mk(0, 2, 0, 3, 6, 0, 0, 0, 0), 0, z);
    add_row(mk(0, 2, 1, 0, -2, 0, 0, 0, 0), 0, z);
    add_row(mk(1, 2, 1, 0, 0, 1, 0, 1, 0), 0, z);
    add_row(mk(1, 2, 3, 2, 1, 2, 3, 2, 1), 0, z);
    add_row(mk(1, 1, 5, 4, 3, 2, 5, 1, -7), 0, z);
    add_row(mk(1, 2, 4, 1, 9, 2, 4, 1, 2), 0, z);
    add_row(mk(0, 2, 32767, 32767, 32767, 3, 0, 0, 0), 0, z);
    add_row(mk(0, 2, -32768, -32768, -32768, 0, 0, 0, 0), 0, z);
    add_row(mk(0, 2, 1, -32768, 32767, 0, 0, 0, 0), 0, z);
    add_row(mk(0, 2, -32768, 32767, 32767, 0, 0, 0, 0), 0, z);
    add_row(mk(0, 1, 0, 1, -32768, 0, 0, 0, 0), 0, z);
    add_row(mk(0, 1, 0, -1, -32768, 0, 0, 0, 0), 0, z);
    add_row(mk(1, 2, 32767, -32768, 32767, 2, -32768, 32767, -32768), 0, z);
    add_row(mk(1, 2, -32768, 32767, -32768, 2, 32767, -32768, 32767), 0, z);
    add_row(mk(1, 2, 1, 1, 1, 1, 0, 3, 1), 0, z);
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    foreach (table_rows[i]) begin
      send(table_rows[i].req);
      if (table_rows[i].typed) solutions_due[$] = table_rows[i].sol;
    end
    for (int i = 0; i < 950; i++) begin
      if (i == 300) hold_start = 1;
      send(random_request());
    end
    s_axis_tvalid <= 0;
    sending_done = 1;
  end

  always @(negedge clk) begin
    if (rst) m_axis_tready <= 0;
    else if (hold_start && !hold_taken) begin
      hold_taken <= 1;
      hold_off <= 200;
      m_axis_tready <= 0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 0;
    end else if ($urandom_range(0, 49) == 0) begin
      hold_off <= $urandom_range(4, 20);
      m_axis_tready <= 0;
    end else
      m_axis_tready <= $urandom_range(0, 3) != 0 || $urandom_range(0, 1) == 0;
  end

  always @(posedge clk) begin
    solution_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      {got.vl, got.vh, got.rl, got.rh, got.disc} = m_axis_tdata;
      got.code = m_axis_tuser;
      if (solutions_due.size() == 0) begin
        $error("result with no request pending");
        errors++;
      end else begin
        want = solutions_due.pop_front();
        if (got.code != want.code) begin
          $error("case_code expected %0d got %0d", want.code, got.code); errors++; end
        if (got.disc != want.disc) begin
          $error("discriminant expected %h got %h", want.disc, got.disc); errors++; end
        if (got.rh != want.rh) begin
          $error("root_high expected %h got %h", want.rh, got.rh); errors++; end
        if (got.rl != want.rl) begin
          $error("root_low expected %h got %h", want.rl, got.rl); errors++; end
        if (got.vh != want.vh) begin
          $error("value_high expected %h got %h", want.vh, got.vh); errors++; end
        if (got.vl != want.vl) begin
          $error("value_low expected %h got %h", want.vl, got.vl); errors++; end
      end
    end
  end

  initial begin
    wait (sending_done);
    while (solutions_due.size() != 0 && cycles < CYCLE_LIMIT) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && solutions_due.size() == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end
endmodule

### filelist.f
design/qri_pkg.sv
design/qri_sqrt_cell.sv
design/qri_div_cell.sv
design/qri_eval.sv
design/quadratic_root_intersection_top.sv
sim/quadratic_root_intersection_top_tb.sv
